>>> rtl/core/gcifb_pkg.sv
// ----------------------------------------------------------------------------
// gcifb_pkg
// Shared types, constants and a helper function for the grid cell indexer.
// ----------------------------------------------------------------------------
package gcifb_pkg;

  localparam int DIMS_DEF = 8;
  localparam int BINS_DEF = 4;

  localparam int DIM_IDX_W = 3;
  localparam int BIN_IDX_W = 2;
  localparam int VALUE_W   = 32;
  localparam int CELL_W    = 16;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } gcifb_op_t;

  // classified item as it travels through the queue
  typedef struct packed {
    logic                       wr_en;
    logic                       smp;
    logic                       dim_ok;
    logic [DIM_IDX_W-1:0]       dim;
    logic [BIN_IDX_W-1:0]       slot;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;
  } gcifb_cmd_t;

  // base^e modulo 2^16, only called with constant arguments
  function automatic logic [CELL_W-1:0] bin_pow(input int base, input int e);
    logic [31:0] p;
    p = 32'd1;
    for (int i = 0; i < e; i++) begin
      p = (p * 32'(base)) & 32'h0000_FFFF;
    end
    return p[CELL_W-1:0];
  endfunction

endpackage

>>> rtl/core/gcifb_if.sv
// ----------------------------------------------------------------------------
// gcifb channel interfaces
// Valid/ready channels for input items and cell index results.
// ----------------------------------------------------------------------------
interface gcifb_in_if;
  logic               valid;
  logic               ready;
  logic [0:0]         opcode;
  logic [2:0]         dim_index;
  logic [1:0]         bin_index;
  logic signed [31:0] value;
  logic               last_dim;

  modport source (output valid, output opcode, output dim_index, output bin_index,
                  output value, output last_dim, input ready);
  modport sink   (input valid, input opcode, input dim_index, input bin_index,
                  input value, input last_dim, output ready);
endinterface

interface gcifb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_index;

  modport source (output valid, output cell_index, input ready);
  modport sink   (input valid, input cell_index, output ready);
endinterface

>>> rtl/core/gcifb_front.sv
// ----------------------------------------------------------------------------
// gcifb_front
// Accepts input items, classifies them and pushes commands into the queue.
// ----------------------------------------------------------------------------
module gcifb_front
  import gcifb_pkg::*;
#(
  parameter int DIMS = DIMS_DEF,
  parameter int BINS = BINS_DEF
) (
  gcifb_in_if.sink   in_ch,
  input  logic       q_full,
  output logic       q_push,
  output gcifb_cmd_t q_cmd
);

  logic dim_ok;
  logic slot_ok;

  assign dim_ok  = 32'(in_ch.dim_index) < DIMS;
  assign slot_ok = 32'(in_ch.bin_index) < (BINS - 1);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_cmd.wr_en  = (in_ch.opcode == OP_LOAD) && dim_ok && slot_ok;
    q_cmd.smp    = (in_ch.opcode == OP_SAMPLE);
    q_cmd.dim_ok = dim_ok;
    q_cmd.dim    = in_ch.dim_index;
    q_cmd.slot   = in_ch.bin_index;
    q_cmd.value  = in_ch.value;
    q_cmd.last   = in_ch.last_dim;
  end

endmodule

>>> rtl/core/gcifb_queue.sv
// ----------------------------------------------------------------------------
// gcifb_queue
// Small command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module gcifb_queue
  import gcifb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  gcifb_cmd_t push_cmd,
  input  logic       pop,
  output logic       full,
  output logic       avail,
  output gcifb_cmd_t head
);

  gcifb_cmd_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign avail = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/gcifb_back.sv
// ----------------------------------------------------------------------------
// gcifb_back
// Boundary table, bin search, index accumulation and result register.
// ----------------------------------------------------------------------------
module gcifb_back
  import gcifb_pkg::*;
#(
  parameter int DIMS = DIMS_DEF,
  parameter int BINS = BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_avail,
  input  gcifb_cmd_t  q_head,
  output logic        q_pop,
  gcifb_out_if.source out_ch
);

  localparam int SLOTS  = BINS - 1;
  localparam int DIM_W  = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BIN_W  = $clog2(BINS);

  // one bank per boundary slot, addressed by dimension
  logic signed [VALUE_W-1:0] bnd_mem [SLOTS][DIMS];
  logic [CELL_W-1:0]         pow_lut [DIMS];

  logic [DIM_W+DIM_IDX_W-1:0]  dim_wide;
  logic [SLOT_W+BIN_IDX_W-1:0] slot_wide;
  logic [DIM_W-1:0]            mem_addr;
  logic [SLOT_W-1:0]           wr_slot;

  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_last_r;
  logic signed [VALUE_W-1:0] s1_value_r;
  logic [CELL_W-1:0]         s1_pow_r;
  logic signed [VALUE_W-1:0] rd_r [SLOTS];

  logic                s1_fire;
  logic                s1_free;
  logic [BIN_W-1:0]    bin;
  logic [BIN_W+CELL_W-1:0] prod;
  logic [CELL_W-1:0]   sum;
  logic [CELL_W-1:0]   acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]   out_idx_r;

  for (genvar d = 0; d < DIMS; d++) begin : g_pow
    assign pow_lut[d] = bin_pow(BINS, d);
  end

  assign dim_wide  = (DIM_W+DIM_IDX_W)'(q_head.dim);
  assign slot_wide = (SLOT_W+BIN_IDX_W)'(q_head.slot);
  assign mem_addr  = q_head.dim_ok ? dim_wide[DIM_W-1:0] : '0;
  assign wr_slot   = slot_wide[SLOT_W-1:0];

  // a record end needs the result register to be free
  assign s1_fire = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign s1_free = !s1_valid_r || s1_fire;
  assign q_pop   = q_avail && s1_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (q_pop) begin
      s1_valid_nxt = q_head.smp;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // first slot whose boundary exceeds the sample, else the open top bin
  always_comb begin
    bin = BIN_W'(BINS - 1);
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (s1_value_r < rd_r[k]) begin
        bin = BIN_W'(k);
      end
    end
  end

  assign prod = (BIN_W+CELL_W)'(bin) * (BIN_W+CELL_W)'(s1_pow_r);
  assign sum  = acc_r + prod[CELL_W-1:0];

  always_comb begin
    acc_nxt = acc_r;
    if (s1_fire) begin
      acc_nxt = s1_last_r ? '0 : sum;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.wr_en) begin
      bnd_mem[wr_slot][mem_addr] <= q_head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.smp) begin
      for (int k = 0; k < SLOTS; k++) begin
        rd_r[k] <= bnd_mem[k][mem_addr];
      end
      s1_value_r <= q_head.value;
      s1_last_r  <= q_head.last;
      // out-of-range dimension contributes nothing
      s1_pow_r   <= q_head.dim_ok ? pow_lut[mem_addr] : '0;
    end
    if (s1_fire && s1_last_r) begin
      out_idx_r <= sum;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_index = out_idx_r;

endmodule

>>> rtl/core/grid_cell_index_from_boundaries.sv
// Path: queue entry, sample stage, result register. Throughput: one item per cycle,
// unless a record end waits on a busy result register; the back side reads all
// boundary banks of one dimension at once, with one multiply-accumulate per cycle.
// Reset: queue, pipeline and result register empty, accumulator zero; the
// boundary table holds no defined value until loaded.
// ----------------------------------------------------------------------------
// grid_cell_index_from_boundaries
// Assigns each record to a grid cell from per-dimension bin boundaries.
// ----------------------------------------------------------------------------
module grid_cell_index_from_boundaries
  import gcifb_pkg::*;
#(
  parameter int DIMS = DIMS_DEF,
  parameter int BINS = BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gcifb_in_if.sink    in_ch,
  gcifb_out_if.source out_ch
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_avail;
  gcifb_cmd_t q_cmd;
  gcifb_cmd_t q_head;

  gcifb_front #(
    .DIMS (DIMS),
    .BINS (BINS)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  gcifb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .avail    (q_avail),
    .head     (q_head)
  );

  gcifb_back #(
    .DIMS (DIMS),
    .BINS (BINS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_avail (q_avail),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> bench/gcifb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcifb_checker
// Watches both channels of the grid cell indexer, tracks the boundary table
// and the running cell sum from accepted items, and compares every cell index
// that leaves the block with the oldest one predicted.
// ----------------------------------------------------------------------------
module gcifb_checker
  import gcifb_pkg::*;
#(
  parameter int DIMS = DIMS_DEF,
  parameter int BINS = BINS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  gcifb_in_if   in_mon,
  gcifb_out_if  out_mon,
  output int    cell_mismatches,
  output int    cells_pending,
  output int    cells_checked
);

  localparam int SLOTS = BINS - 1;

  logic signed [VALUE_W-1:0] bounds [DIMS*SLOTS];
  logic [CELL_W-1:0]         cell_sum;
  logic [CELL_W-1:0]         expected_cells [$];
  int                        mismatch_cnt;
  int                        checked_cnt;

  // weight of one bin step in dimension dim, wraps at 16 bits
  function automatic logic [CELL_W-1:0] dim_weight(input int dim);
    logic [CELL_W-1:0] w;
    w = CELL_W'(1);
    for (int i = 0; i < dim; i++) begin
      w = w * CELL_W'(BINS);
    end
    return w;
  endfunction

  // first slot whose boundary lies above the value, top bin otherwise
  function automatic int bin_of(input int dim, input logic signed [VALUE_W-1:0] v);
    for (int k = 0; k < SLOTS; k++) begin
      if (v < bounds[dim*SLOTS+k]) return k;
    end
    return BINS - 1;
  endfunction

  task automatic flag_cell(input string what, input logic [CELL_W-1:0] exp_cell,
                           input logic [CELL_W-1:0] got_cell);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] cell_index %s: expected 0x%04h, got 0x%04h", $realtime, what,
               exp_cell, got_cell);
    end
  endtask

  always @(posedge clk) begin
    logic [CELL_W-1:0] sum_next;
    logic [CELL_W-1:0] exp_cell;
    if (!rst_n) begin
      cell_sum = '0;
      expected_cells.delete();
      mismatch_cnt = 0;
      checked_cnt  = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (gcifb_op_t'(in_mon.opcode) == OP_LOAD) begin
          // out-of-range slots are dropped by the block
          if (in_mon.bin_index < SLOTS && in_mon.dim_index < DIMS) begin
            bounds[in_mon.dim_index*SLOTS + in_mon.bin_index] = in_mon.value;
          end
        end else begin
          sum_next = cell_sum;
          if (in_mon.dim_index < DIMS) begin
            sum_next = sum_next + CELL_W'(bin_of(in_mon.dim_index, in_mon.value))
                                  * dim_weight(in_mon.dim_index);
          end
          if (in_mon.last_dim) begin
            expected_cells.push_back(sum_next);
            sum_next = '0;
          end
          cell_sum = sum_next;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        checked_cnt++;
        if (expected_cells.size() == 0) begin
          flag_cell("with no record pending", '0, out_mon.cell_index);
        end else begin
          exp_cell = expected_cells.pop_front();
          if (out_mon.cell_index !== exp_cell) begin
            flag_cell("mismatch", exp_cell, out_mon.cell_index);
          end
        end
      end
    end
    cell_mismatches <= mismatch_cnt;
    cells_pending   <= expected_cells.size();
    cells_checked   <= checked_cnt;
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives boundary loads and record elements into the grid cell indexer with
// random gaps and result stalls; the checker beside the block predicts and
// compares every cell index, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import gcifb_pkg::*;

  localparam int SLOTS        = BINS_DEF - 1;
  localparam int RANDOM_ITEMS = 2000;
  localparam int QUIET_LIMIT  = 2000;

  logic clk;
  logic rst_n;

  gcifb_in_if  in_ch ();
  gcifb_out_if out_ch ();

  int cell_mismatches;
  int cells_pending;
  int cells_checked;

  bit in_idle_on;
  bit out_idle_on;
  int items_sent;
  int n_loads;
  int n_samples;
  int quiet_cycles;

  // boundaries as loaded, used only to aim sample values near them
  logic signed [31:0] shadow_bounds [DIMS_DEF*SLOTS];

  grid_cell_index_from_boundaries #(
    .DIMS (DIMS_DEF),
    .BINS (BINS_DEF)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gcifb_checker #(
    .DIMS (DIMS_DEF),
    .BINS (BINS_DEF)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cell_mismatches (cell_mismatches),
    .cells_pending   (cells_pending),
    .cells_checked   (cells_checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side stalls in bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d cells pending", quiet_cycles,
               cells_pending);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input gcifb_op_t op, input int dim, input int slot,
                           input logic [31:0] val, input bit last);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.dim_index <= 3'(dim);
    in_ch.bin_index <= 2'(slot);
    in_ch.value     <= val;
    in_ch.last_dim  <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (op == OP_LOAD) begin
      n_loads++;
      if (slot < SLOTS) shadow_bounds[dim*SLOTS + slot] = val;
    end else begin
      n_samples++;
    end
  endtask

  // hold off the sender until every record's cell index is back
  task automatic drain_cells();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(input int dim);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1, 2, 3: return $urandom();
      default: return shadow_bounds[dim*SLOTS + $urandom_range(0, SLOTS-1)]
                      + 32'($urandom_range(0, 2)) - 32'd1;
    endcase
  endfunction

  task automatic send_record(input int len, input bit scrambled);
    int dim;
    for (int i = 0; i < len; i++) begin
      dim = scrambled ? $urandom_range(0, DIMS_DEF-1) : i;
      send_item(OP_SAMPLE, dim, $urandom_range(0, 3), pick_value(dim), i == len - 1);
    end
  endtask

  task automatic reload_dim(input int dim);
    logic signed [31:0] a, b, c, t;
    a = $urandom();
    b = $urandom();
    c = $urandom();
    if ($urandom_range(0, 1)) begin
      // narrow spread so nearby samples cross several bins
      a = a >>> 12;
      b = b >>> 12;
      c = c >>> 12;
    end
    if ($urandom_range(0, 3) != 0) begin
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
    end
    send_item(OP_LOAD, dim, 0, a, 1'($urandom_range(0, 1)));
    send_item(OP_LOAD, dim, 1, b, 1'($urandom_range(0, 1)));
    send_item(OP_LOAD, dim, 2, c, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [31:0] val;
    int          rand_base;
    int          next_mode_at;
    int          mode;
    int          pick;
    bit          drained_mid;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_LOAD;
    in_ch.dim_index <= '0;
    in_ch.bin_index <= '0;
    in_ch.value     <= '0;
    in_ch.last_dim  <= 1'b0;
    in_idle_on   = 1'b1;
    out_idle_on  = 1'b1;
    items_sent   = 0;
    n_loads      = 0;
    n_samples    = 0;
    drained_mid  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table first, last dimension at the value extremes
    for (int d = 0; d < DIMS_DEF; d++) begin
      for (int k = 0; k < SLOTS; k++) begin
        if (d == DIMS_DEF - 1) begin
          val = (k == 0) ? 32'h8000_0001 : (k == 1) ? 32'h0 : 32'h7FFF_FFFF;
        end else begin
          val = 32'((k - 1) * (d + 1) * 65536);
        end
        send_item(OP_LOAD, d, k, val, k[0]);
      end
    end
    // slot past the stored boundaries is dropped
    send_item(OP_LOAD, 2, 3, 32'h7FFF_FFFF, 1'b1);
    // every dimension in its top bin, then every one in bin zero
    for (int d = 0; d < DIMS_DEF; d++) begin
      send_item(OP_SAMPLE, d, 3, 32'h7FFF_FFFF, d == DIMS_DEF - 1);
    end
    for (int d = 0; d < DIMS_DEF; d++) begin
      send_item(OP_SAMPLE, d, 0, 32'h8000_0000, d == DIMS_DEF - 1);
    end
    // value equal to a boundary, one-element record
    send_item(OP_SAMPLE, 0, 1, 32'h0, 1'b1);
    // repeated top dimension wraps the sum past 16 bits
    send_item(OP_SAMPLE, 7, 2, 32'h7FFF_FFFE, 1'b0);
    send_item(OP_SAMPLE, 7, 3, 32'h0, 1'b1);
    drain_cells();

    rand_base    = items_sent;
    next_mode_at = 0;
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      if (items_sent - rand_base >= RANDOM_ITEMS - 300) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end else if (items_sent - rand_base >= next_mode_at) begin
        mode         = $urandom_range(0, 3);
        in_idle_on   = mode[0];
        out_idle_on  = mode[1];
        next_mode_at += 250;
      end
      if (!drained_mid && items_sent - rand_base >= RANDOM_ITEMS / 2) begin
        drain_cells();
        drained_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_record($urandom_range(1, DIMS_DEF), $urandom_range(0, 4) == 0);
      end else if (pick < 85) begin
        reload_dim($urandom_range(0, DIMS_DEF-1));
      end else if (pick < 95) begin
        send_item(OP_LOAD, $urandom_range(0, DIMS_DEF-1), $urandom_range(0, 3), $urandom(),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(OP_SAMPLE, $urandom_range(0, DIMS_DEF-1), $urandom_range(0, 3),
                  $urandom(), 1'($urandom_range(0, 1)));
      end
    end

    drain_cells();
    repeat (10) @(posedge clk);
    $display("covered %0d boundary loads and %0d record elements, %0d cell indexes checked",
             n_loads, n_samples, cells_checked);
    if (cell_mismatches == 0 && cells_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d cells never returned", cell_mismatches, cells_pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
